// ----- src/ncp_pkg.sv -----
// ----------------------------------------------------------------------------
// ncp_pkg
// Types and constants shared by the coordinate parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ncp_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int WHOLE_W = 17;
  localparam int FRAC_W  = 14;
  localparam int CNT_W   = 3;
  localparam int TOK_W   = 4;

  localparam logic [TOK_W-1:0] TOK_MAX = 4'd15;
  localparam logic [CNT_W-1:0] WHOLE_KEEP = 3'd5;
  localparam logic [CNT_W-1:0] WHOLE_SAT  = 3'd7;
  localparam logic [CNT_W-1:0] LAT_MAX_DIGITS = 3'd4;
  localparam logic [CNT_W-1:0] LON_MAX_DIGITS = 3'd5;

  // floor(x / 100) = (x * DIV100_MUL) >> DIV_SHIFT for x < 2^17
  localparam logic [17:0] DIV100_MUL = 18'd167773;
  // floor(x / 3) = (x * DIV3_MUL) >> DIV_SHIFT for x < 2^21
  localparam logic [22:0] DIV3_MUL   = 23'd5592406;
  localparam int          DIV_SHIFT  = 24;
  localparam logic [23:0] DEG_SCALE  = 24'd10000000;
  localparam logic [13:0] MIN_SCALE  = 14'd10000;

  typedef enum logic [0:0] {
    REG_LAT_TOKEN = 1'b0,
    REG_LON_TOKEN = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic [CNT_W-1:0]   fdigits;
  } coord_raw_t;

  // pads a short fraction out to four digits
  function automatic logic [FRAC_W-1:0] frac_scale(input logic [CNT_W-1:0] fd);
    logic [FRAC_W-1:0] s;
    case (fd)
      3'd0:    s = 14'd10000;
      3'd1:    s = 14'd1000;
      3'd2:    s = 14'd100;
      3'd3:    s = 14'd10;
      default: s = 14'd1;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- src/nmea_coordinate_parser_unit.sv -----
// Output: a result appears on the master side after the edge that transfers
//   the byte marked tlast (one parse stage, then a five-stage conversion pipeline).
// Throughput: one sentence byte per cycle unless the output stalls, a new sentence may start the next cycle;
//   the conversion pipeline advances whenever its output register is free or taken.
// Reset: synchronous, clears the parse state except lat_raw/lon_raw, and the flags; token indexes return to 1 and 3.
// ----------------------------------------------------------------------------
// nmea_coordinate_parser_unit
// Splits a sentence into comma tokens and converts the latitude and longitude
// tokens into degrees in units of 1e-7.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_coordinate_parser_unit #(
  parameter int MAX_SENTENCE_BYTES = 82,
  parameter int FRACTION_DIGITS    = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] sentence_byte
  input  wire logic                 s_tlast,   // final_byte
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [63:0]               m_tdata,   // [29:0] latitude_e7, [63:30] longitude_e7
  output logic [1:0]                m_tuser,   // [0] latitude_valid, [1] longitude_valid
  input  wire logic                 cfg_wen,
  input  wire ncp_pkg::reg_index_t  cfg_index,
  input  wire logic [3:0]           cfg_data
);
  import ncp_pkg::*;

  localparam int POS_W = $clog2(MAX_SENTENCE_BYTES + 1);

  logic [TOK_W-1:0] lat_token;
  logic [TOK_W-1:0] lon_token;

  logic [POS_W-1:0]   pos;
  logic [TOK_W-1:0]   tok;
  logic               inside_token;
  logic               after_point;
  logic               ended;
  logic [WHOLE_W-1:0] whole;
  logic [CNT_W-1:0]   wcount;
  logic [FRAC_W-1:0]  frac;
  logic [CNT_W-1:0]   fcount;
  coord_raw_t         lat_raw;
  coord_raw_t         lon_raw;
  logic [1:0]         flags;

  logic [POS_W-1:0]   pos_next;
  logic [TOK_W-1:0]   tok_next;
  logic               inside_token_next;
  logic               after_point_next;
  logic               ended_next;
  logic [WHOLE_W-1:0] whole_next;
  logic [CNT_W-1:0]   wcount_next;
  logic [FRAC_W-1:0]  frac_next;
  logic [CNT_W-1:0]   fcount_next;
  coord_raw_t         lat_raw_next;
  coord_raw_t         lon_raw_next;
  logic [1:0]         flags_next;

  logic       adv;
  logic       take;
  logic       proc;
  logic       is_sep;
  logic       is_digit;
  logic [3:0] dv;
  logic       end_now;
  coord_raw_t tok_raw;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_token <= 4'd1;
      lon_token <= 4'd3;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_LAT_TOKEN: lat_token <= cfg_data;
        REG_LON_TOKEN: lon_token <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte parse
  always_comb begin
    proc     = !ended && (pos < POS_W'(MAX_SENTENCE_BYTES));
    is_sep   = (s_tdata == CHAR_NUL) || (s_tdata == CHAR_COMMA);
    is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    dv       = is_digit ? 4'(s_tdata - CHAR_ZERO) : 4'd0;

    pos_next          = proc ? pos + POS_W'(1) : pos;
    ended_next        = ended || (proc && (s_tdata == CHAR_NUL));
    tok_next          = tok;
    inside_token_next = inside_token;
    after_point_next  = after_point;
    whole_next        = whole;
    wcount_next       = wcount;
    frac_next         = frac;
    fcount_next       = fcount;

    if (proc && !is_sep) begin
      inside_token_next = 1'b1;
      if ((s_tdata == CHAR_POINT) && !after_point) begin
        after_point_next = 1'b1;
      end else if (!after_point) begin
        if (wcount < WHOLE_KEEP) begin
          whole_next = WHOLE_W'(whole * WHOLE_W'(10)) + WHOLE_W'(dv);
        end
        if (wcount < WHOLE_SAT) begin
          wcount_next = wcount + CNT_W'(1);
        end
      end else if (fcount < CNT_W'(FRACTION_DIGITS)) begin
        frac_next   = FRAC_W'(frac * FRAC_W'(10)) + FRAC_W'(dv);
        fcount_next = fcount + CNT_W'(1);
      end
    end

    tok_raw = '{whole: whole_next, frac: frac_next, fdigits: fcount_next};
    end_now = inside_token_next && (s_tlast || (proc && is_sep));

    lat_raw_next = lat_raw;
    lon_raw_next = lon_raw;
    flags_next   = flags;

    if (end_now) begin
      if (tok == lat_token) begin
        if ((wcount_next != '0) && (wcount_next <= LAT_MAX_DIGITS)) begin
          lat_raw_next  = tok_raw;
          flags_next[0] = 1'b1;
        end else begin
          flags_next[0] = 1'b0;
        end
      end
      if (tok == lon_token) begin
        if ((wcount_next != '0) && (wcount_next <= LON_MAX_DIGITS)) begin
          lon_raw_next  = tok_raw;
          flags_next[1] = 1'b1;
        end else begin
          flags_next[1] = 1'b0;
        end
      end
      if (tok != TOK_MAX) begin
        tok_next = tok + TOK_W'(1);
      end
      inside_token_next = 1'b0;
      after_point_next  = 1'b0;
      whole_next        = '0;
      wcount_next       = '0;
      frac_next         = '0;
      fcount_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      tok          <= '0;
      inside_token <= 1'b0;
      after_point  <= 1'b0;
      ended        <= 1'b0;
      whole        <= '0;
      wcount       <= '0;
      frac         <= '0;
      fcount       <= '0;
      flags        <= '0;
    end else if (take) begin
      if (s_tlast) begin
        pos    <= '0;
        tok    <= '0;
        ended  <= 1'b0;
        flags  <= '0;
      end else begin
        pos    <= pos_next;
        tok    <= tok_next;
        ended  <= ended_next;
        flags  <= flags_next;
      end
      inside_token <= inside_token_next;
      after_point  <= after_point_next;
      whole        <= whole_next;
      wcount       <= wcount_next;
      frac         <= frac_next;
      fcount       <= fcount_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      lat_raw <= lat_raw_next;
      lon_raw <= lon_raw_next;
    end
  end

  // conversion pipeline
  logic v1, v2, v3, v4, v5;
  logic [1:0] f1, f2, f3, f4, f5;

  coord_raw_t         s1_raw  [2];
  logic [10:0]        s2_deg  [2];
  logic [WHOLE_W-1:0] s2_whole[2];
  logic [FRAC_W-1:0]  s2_fsc  [2];
  logic [6:0]         s3_rem  [2];
  logic [33:0]        s3_dege7[2];
  logic [FRAC_W-1:0]  s3_fsc  [2];
  logic [19:0]        s4_mins [2];
  logic [33:0]        s4_dege7[2];
  logic [19:0]        s5_q    [2];
  logic [33:0]        s5_base [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= take && s_tlast;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      m_tvalid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_raw[0] <= lat_raw_next;
      s1_raw[1] <= lon_raw_next;
      f1 <= flags_next;
      f2 <= f1;
      f3 <= f2;
      f4 <= f3;
      f5 <= f4;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [34:0] div100_prod;
    logic [27:0] fsc_prod;
    logic [16:0] rem_diff;
    logic [34:0] dege7_prod;
    logic [43:0] div3_prod;

    assign div100_prod = 35'(s1_raw[l].whole) * 35'(DIV100_MUL);
    assign fsc_prod    = 28'(s1_raw[l].frac) * 28'(frac_scale(s1_raw[l].fdigits));
    assign rem_diff    = s2_whole[l] - WHOLE_W'(17'(s2_deg[l]) * 17'd100);
    assign dege7_prod  = 35'(s2_deg[l]) * 35'(DEG_SCALE);
    assign div3_prod   = 44'({s4_mins[l], 1'b0}) * 44'(DIV3_MUL);

    always_ff @(posedge clk) begin
      if (adv) begin
        s2_deg[l]   <= div100_prod[34:DIV_SHIFT];
        s2_whole[l] <= s1_raw[l].whole;
        s2_fsc[l]   <= fsc_prod[FRAC_W-1:0];
        s3_rem[l]   <= rem_diff[6:0];
        s3_dege7[l] <= dege7_prod[33:0];
        s3_fsc[l]   <= s2_fsc[l];
        s4_mins[l]  <= 20'(20'(s3_rem[l]) * 20'(MIN_SCALE)) + 20'(s3_fsc[l]);
        s4_dege7[l] <= s3_dege7[l];
        s5_q[l]     <= div3_prod[43:DIV_SHIFT];
        s5_base[l]  <= s4_dege7[l] + 34'({s4_mins[l], 4'b0000});
      end
    end
  end

  logic [33:0] lat_sum;
  logic [33:0] lon_sum;

  assign lat_sum = s5_base[0] + 34'(s5_q[0]);
  assign lon_sum = s5_base[1] + 34'(s5_q[1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata[29:0]  <= f5[0] ? lat_sum[29:0] : '0;
      m_tdata[63:30] <= f5[1] ? lon_sum : '0;
      m_tuser        <= f5;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_SENTENCE_BYTES))
    else $error("byte position past sentence limit");

  assert property (@(posedge clk) disable iff (rst)
    !inside_token |-> (whole == '0) && (wcount == '0) && (frac == '0) && (fcount == '0)
                      && !after_point)
    else $error("token accumulators not clear outside a token");

  assert property (@(posedge clk) disable iff (rst)
    take && s_tlast |=> (pos == '0) && (tok == '0) && !ended && (flags == '0))
    else $error("sentence state not cleared after final byte");

  assert property (@(posedge clk) disable iff (rst)
    ended && !take |=> $stable(pos))
    else $error("byte position moved after sentence end");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] || (m_tdata[29:0] == '0))
                 && (m_tuser[1] || (m_tdata[63:30] == '0)))
    else $error("coordinate nonzero without its valid flag");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[29:0] <= 30'd1006666650)
    else $error("latitude out of range");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Streams sentence bytes into the coordinate parser and checks every
// latitude/longitude result against a cycle-free software copy of the
// parser. Token indexes are reprogrammed between sentences, and both sides
// of the stream are throttled in several phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ncp_pkg::*;

  localparam int SENTENCE_LIMIT = 82;
  localparam int FRAC_KEEP      = 4;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic [29:0] lat;
    logic [33:0] lon;
    logic [1:0]  flags;
  } fix_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_wen = 1'b0;
  reg_index_t  cfg_index = REG_LAT_TOKEN;
  logic [3:0]  cfg_data = 4'd0;

  nmea_coordinate_parser_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // parser state mirror
  logic [3:0]  lat_sel = 4'd1;
  logic [3:0]  lon_sel = 4'd3;
  logic [6:0]  byte_pos;
  logic [3:0]  tok_idx;
  logic        in_tok;
  logic        seen_point;
  logic        sentence_done;
  logic [16:0] whole_acc;
  logic [2:0]  whole_cnt;
  logic [13:0] frac_acc;
  logic [2:0]  frac_cnt;
  logic [29:0] lat_fix;
  logic [33:0] lon_fix;
  logic [1:0]  fix_flags;

  fix_t        expected_fixes[$];
  logic [7:0]  sentence_q[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin : check_fixes
    fix_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_fixes.size() == 0) begin
        $display("%0t unexpected result: expected none, actual tdata %h tuser %b",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = expected_fixes.pop_front();
        if (m_tdata[29:0] !== want.lat) begin
          $display("%0t latitude_e7: expected %0d, actual %0d", $time, want.lat,
                   m_tdata[29:0]);
          errors++;
        end
        if (m_tdata[63:30] !== want.lon) begin
          $display("%0t longitude_e7: expected %0d, actual %0d", $time, want.lon,
                   m_tdata[63:30]);
          errors++;
        end
        if (m_tuser !== want.flags) begin
          $display("%0t valid flags: expected %b, actual %b", $time, want.flags, m_tuser);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_token_state();
    in_tok     = 1'b0;
    seen_point = 1'b0;
    whole_acc  = '0;
    whole_cnt  = '0;
    frac_acc   = '0;
    frac_cnt   = '0;
  endfunction

  function automatic void clear_sentence_state();
    byte_pos      = '0;
    tok_idx       = '0;
    sentence_done = 1'b0;
    clear_token_state();
    lat_fix   = '0;
    lon_fix   = '0;
    fix_flags = '0;
  endfunction

  function automatic logic [33:0] degrees_e7();
    longint unsigned padded_frac;
    longint unsigned degs;
    longint unsigned mins;
    case (frac_cnt)
      3'd0:    padded_frac = longint'(frac_acc) * 10000;
      3'd1:    padded_frac = longint'(frac_acc) * 1000;
      3'd2:    padded_frac = longint'(frac_acc) * 100;
      3'd3:    padded_frac = longint'(frac_acc) * 10;
      default: padded_frac = longint'(frac_acc);
    endcase
    degs = whole_acc / 100;
    mins = longint'(whole_acc % 100) * 10000 + padded_frac;
    return 34'(degs * 10000000 + (mins * 100) / 6);
  endfunction

  function automatic void close_token();
    logic [33:0] deg_val;
    if (!in_tok) return;
    deg_val = degrees_e7();
    if (tok_idx == lat_sel) begin
      if (whole_cnt >= 1 && whole_cnt <= LAT_MAX_DIGITS) begin
        lat_fix      = deg_val[29:0];
        fix_flags[0] = 1'b1;
      end else begin
        lat_fix      = '0;
        fix_flags[0] = 1'b0;
      end
    end
    if (tok_idx == lon_sel) begin
      if (whole_cnt >= 1 && whole_cnt <= LON_MAX_DIGITS) begin
        lon_fix      = deg_val;
        fix_flags[1] = 1'b1;
      end else begin
        lon_fix      = '0;
        fix_flags[1] = 1'b0;
      end
    end
    if (tok_idx != TOK_MAX) tok_idx++;
    clear_token_state();
  endfunction

  function automatic void take_char(input logic [7:0] c);
    logic [3:0] v;
    if (c == CHAR_NUL) begin
      close_token();
      sentence_done = 1'b1;
      return;
    end
    if (c == CHAR_COMMA) begin
      close_token();
      return;
    end
    if (!in_tok) begin
      clear_token_state();
      in_tok = 1'b1;
    end
    if (c == CHAR_POINT && !seen_point) begin
      seen_point = 1'b1;
      return;
    end
    v = (c >= CHAR_ZERO && c <= CHAR_NINE) ? 4'(c - CHAR_ZERO) : 4'd0;
    if (!seen_point) begin
      if (whole_cnt < WHOLE_KEEP) whole_acc = 17'(whole_acc * 10 + v);
      if (whole_cnt < WHOLE_SAT) whole_cnt++;
    end else if (frac_cnt < FRAC_KEEP) begin
      frac_acc = 14'(frac_acc * 10 + v);
      frac_cnt++;
    end
  endfunction

  function automatic void parse_sentence_byte(input logic [7:0] c, input logic last);
    fix_t f;
    if (!sentence_done && byte_pos < SENTENCE_LIMIT) begin
      byte_pos++;
      take_char(c);
    end
    if (last) begin
      close_token();
      f.lat   = fix_flags[0] ? lat_fix : '0;
      f.lon   = fix_flags[1] ? lon_fix : '0;
      f.flags = fix_flags;
      expected_fixes.push_back(f);
      clear_sentence_state();
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] c, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_sentence_byte(c, last);
  endtask

  task automatic send_sentence(output int n);
    n = sentence_q.size();
    for (int i = 0; i < n; i++) send_byte(sentence_q[i], i == n - 1);
  endtask

  task automatic drain_fixes();
    s_tvalid <= 1'b0;
    while (expected_fixes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_token_index(input reg_index_t idx, input logic [3:0] val);
    drain_fixes();
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_LAT_TOKEN) lat_sel = val;
    else lon_sel = val;
  endtask

  task automatic set_token_indexes(input logic [3:0] lat, input logic [3:0] lon);
    write_token_index(REG_LAT_TOKEN, lat);
    write_token_index(REG_LON_TOKEN, lon);
  endtask

  task automatic pick_token_indexes();
    logic [3:0] lat;
    logic [3:0] lon;
    int r;
    r = $urandom_range(9);
    if (r < 6) begin
      lat = 4'($urandom_range(1, 4));
      lon = lat + 4'($urandom_range(1, 3));
    end else if (r == 6) begin
      lat = 4'($urandom_range(0, 6));
      lon = lat;
    end else if (r == 7) begin
      lat = TOK_MAX;
      lon = 4'($urandom_range(0, 15));
    end else if (r == 8) begin
      lat = 4'd0;
      lon = TOK_MAX;
    end else begin
      lat = 4'($urandom);
      lon = 4'($urandom);
    end
    set_token_indexes(lat, lon);
  endtask

  // ---------------------------------------------------------------- sentence builder

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) sentence_q.push_back(s[i]);
  endfunction

  // digits with the odd stray character
  function automatic void push_digit(input int d);
    if ($urandom_range(99) < 3) sentence_q.push_back(8'($urandom_range(33, 126)));
    else sentence_q.push_back(CHAR_ZERO + 8'(d));
  endfunction

  function automatic void add_coordinate();
    int r;
    int nint;
    int nfrac;
    bit nines;
    r     = $urandom_range(99);
    nint  = (r < 5) ? 0 : (r < 12) ? $urandom_range(6, 7) : $urandom_range(1, 5);
    nines = ($urandom_range(9) == 0);
    for (int i = 0; i < nint; i++) begin
      if (nines) push_digit((i == nint - 2) ? 5 : 9);
      else push_digit($urandom_range(9));
    end
    if (nint == 0 || $urandom_range(99) < 85) begin
      sentence_q.push_back(CHAR_POINT);
      nfrac = $urandom_range(0, 6);
      for (int i = 0; i < nfrac; i++) begin
        if ($urandom_range(99) < 4) sentence_q.push_back(CHAR_POINT);
        else push_digit(nines ? 9 : $urandom_range(9));
      end
    end
  endfunction

  function automatic void add_filler();
    string pool;
    int n;
    pool = "NESWAM0123456789.";
    n    = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) sentence_q.push_back(pool[$urandom_range(pool.len() - 1)]);
  endfunction

  function automatic void build_sentence();
    int ntok;
    int top;
    sentence_q.delete();
    if ($urandom_range(49) == 0) begin
      sentence_q.push_back(8'($urandom));
      return;
    end
    top  = (lat_sel > lon_sel) ? int'(lat_sel) : int'(lon_sel);
    ntok = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : top + 1 + $urandom_range(0, 2);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) sentence_q.push_back(CHAR_COMMA);
      if (t == lat_sel || t == lon_sel || (t >= TOK_MAX && top == TOK_MAX)) begin
        if ($urandom_range(99) < 88) add_coordinate();
        else add_filler();
      end else if (t == 0) begin
        push_text("$GPGGA");
      end else begin
        add_filler();
      end
      if ($urandom_range(99) < 3) sentence_q.push_back(CHAR_COMMA);
      if ($urandom_range(99) < 3) sentence_q.push_back(8'($urandom));
    end
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(20, 60)) sentence_q.push_back(8'($urandom_range(32, 126)));
    end
    if ($urandom_range(99) < 25) begin
      case ($urandom_range(2))
        0:       sentence_q.push_back(8'h0D);
        1:       push_text("*");
        default: sentence_q.push_back(CHAR_COMMA);
      endcase
    end
  endfunction

  task automatic run_random_sentences(input int n_bytes, input int idle_pct,
                                      input int stall_pct);
    int sent;
    int k;
    int n;
    sent = 0;
    k    = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_bytes) begin
      if (k % 4 == 0) pick_token_indexes();
      build_sentence();
      send_sentence(n);
      sent += n;
      k++;
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    int n;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_token_indexes(4'd0, 4'd1);
    sentence_q.delete();
    push_text("9959.99999,99959.9999");
    send_sentence(n);
    sentence_q.delete();
    push_text(".5,1.2.3");
    send_sentence(n);
    sentence_q.delete();
    push_text("123456,a1:");
    send_sentence(n);
    sentence_q.delete();
    push_text("1");
    sentence_q.push_back(CHAR_NUL);
    push_text("2,3");
    send_sentence(n);
    sentence_q.delete();
    push_text(",0,0");
    send_sentence(n);
    sentence_q.delete();
    push_text(",");
    send_sentence(n);
  endtask

  task automatic test_no_idling();
    run_random_sentences(475, 0, 0);
  endtask

  task automatic test_slow_sender();
    run_random_sentences(475, 88, 0);
  endtask

  task automatic test_slow_receiver();
    run_random_sentences(475, 0, 88);
  endtask

  task automatic test_both_idling();
    run_random_sentences(475, 9, 9);
  endtask

  task automatic finish_run();
    drain_fixes();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  endtask

  initial begin
    clear_sentence_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_no_idling();
    test_slow_sender();
    test_slow_receiver();
    test_both_idling();
    finish_run();
  end

endmodule
